### hdl/tds_pkg.sv
package tds_pkg;

   localparam int SLOT_COUNT     = 256;
   localparam int SLOT_W         = 8;
   localparam int READY_DEPTH    = 256;
   localparam int READY_W        = 8;
   localparam int MAX_DEPENDENTS = 16;
   localparam int DEP_W          = 4;
   localparam int MAX_WORKERS    = 32;
   localparam int EPOCH_BITS     = 24;
   localparam int DEPS_MAX       = 511;

   localparam logic [2:0] CMD_ALLOC    = 3'd0;
   localparam logic [2:0] CMD_SCALAR   = 3'd1;
   localparam logic [2:0] CMD_INDEXED  = 3'd2;
   localparam logic [2:0] CMD_ADD_DEP  = 3'd3;
   localparam logic [2:0] CMD_SUBMIT   = 3'd4;
   localparam logic [2:0] CMD_TAKE     = 3'd5;
   localparam logic [2:0] CMD_DONE     = 3'd6;
   localparam logic [2:0] CMD_QUERY    = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_FREE   = 3'd1;
   localparam logic [2:0] ST_READY_FULL = 3'd2;
   localparam logic [2:0] ST_STALE     = 3'd3;
   localparam logic [2:0] ST_DEPS_FULL = 3'd4;
   localparam logic [2:0] ST_EMPTY     = 3'd5;

   localparam logic [1:0] KIND_INDEXED = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  task_slot;
      logic [23:0] task_epoch;
      logic [7:0]  other_slot;
      logic [23:0] other_epoch;
      logic [31:0] work_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_slot;
      logic [23:0] out_epoch;
      logic [1:0]  out_kind;
      logic        finished;
   } rsp_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [8:0]            deps;
      logic [5:0]            workers;
      logic [1:0]            kind;
      logic [31:0]           limit;
      logic [4:0]            dep_cnt;
   } slot_info_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [SLOT_W-1:0]     slot;
   } handle_type;

   function automatic logic [5:0] entries_for(slot_info_type info, logic [5:0] wc);
      logic [5:0] w;
      logic [5:0] n;
      if (wc == 6'd0) begin
         w = 6'd1;
      end else if (wc > 6'(MAX_WORKERS)) begin
         w = 6'(MAX_WORKERS);
      end else begin
         w = wc;
      end
      n = (info.limit < {26'd0, w}) ? info.limit[5:0] : w;
      if (info.kind != KIND_INDEXED) begin
         return 6'd1;
      end
      return (n == 6'd0) ? 6'd1 : n;
   endfunction

endpackage

### hdl/task_dependency_scheduler_core.sv
// Result beat: assign, submit, query, non-final worker done and errors seen on the first read
// answer from that read; allocate, take ready and add dependency read a second slot first, and
// add on another task writes that slot too. Last worker done reads each recorded dependent to
// check ready space (ready full is answered there), then updates each and pushes ready entries.
// One command at a time, submit's entries pushed first; two may queue. Reset: synchronous; busy
// stays high while slot table and free ring are swept. Results strobe one cycle and cannot be stalled.
module task_dependency_scheduler_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tds_pkg::req_type req_item,
   output logic             rsp_strobe,
   output tds_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [5:0]       csr_data
);
   import tds_pkg::*;

   logic    head_valid, pop, init_busy;
   req_type head_item;

   assign csr_ready = 1'b1;

   tds_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .hold(init_busy), .busy(busy), .head_valid(head_valid),
      .head_item(head_item), .pop(pop)
   );

   tds_back u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head_item(head_item),
      .pop(pop), .init_busy(init_busy), .csr_valid(csr_valid & csr_ready),
      .csr_data(csr_data), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.status <= ST_EMPTY)
      else $error("status code out of range");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != ST_OK |->
         rsp_item.out_slot == '0 && rsp_item.out_epoch == '0 &&
         rsp_item.out_kind == '0 && !rsp_item.finished)
      else $error("error beat carries payload");

endmodule

### hdl/tds_ram.sv
module tds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/tds_front.sv
module tds_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  tds_pkg::req_type req_item,
   input  logic            hold,
   output logic            busy,
   output logic            head_valid,
   output tds_pkg::req_type head_item,
   input  logic            pop
);
   import tds_pkg::*;

   req_type    q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;

   assign busy       = hold | (count_ff == 2'd2);
   assign push       = start & ~busy;
   assign head_valid = count_ff != 2'd0;
   assign head_item  = q_ff[rd_ff];

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= req_item;
      end
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

endmodule

### hdl/tds_back.sv
module tds_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  tds_pkg::req_type head_item,
   output logic             pop,
   output logic             init_busy,
   input  logic             csr_valid,
   input  logic [5:0]       csr_data,
   output logic             rsp_strobe,
   output tds_pkg::rsp_type rsp_item
);
   import tds_pkg::*;

   typedef enum logic [16:0] {
      S_INIT     = 17'h00001,
      S_IDLE     = 17'h00002,
      S_WAIT     = 17'h00004,
      S_EXEC     = 17'h00008,
      S_ALLOC_WR = 17'h00010,
      S_ADD2     = 17'h00020,
      S_ADD3     = 17'h00040,
      S_TAKE2    = 17'h00080,
      S_P1_RDH   = 17'h00100,
      S_P1_GOTH  = 17'h00200,
      S_P1_EVAL  = 17'h00400,
      S_P1_END   = 17'h00800,
      S_P2_START = 17'h01000,
      S_P2_EVAL  = 17'h02000,
      S_FIN      = 17'h04000,
      S_FIN2     = 17'h08000,
      S_PUSH     = 17'h10000
   } state_type;

   state_type     state_ff, state_in, ret_ff, ret_in;
   req_type       cmd_ff, cmd_in;
   logic [7:0]    t_ff, t_in;
   logic [4:0]    idx_ff, idx_in, cnt_ff, cnt_in, k_ff, k_in;
   logic [9:0]    need_ff, need_in;
   handle_type    h_ff, h_in;
   handle_type    hbuf_ff [MAX_DEPENDENTS];
   handle_type    hbuf_in [MAX_DEPENDENTS];
   slot_info_type info_s_ff, info_s_in;
   logic [5:0]    push_left_ff, push_left_in;
   logic [7:0]    push_slot_ff, push_slot_in;
   logic [7:0]    free_rd_ff, free_rd_in, free_wr_ff, free_wr_in;
   logic [8:0]    free_cnt_ff, free_cnt_in;
   logic [7:0]    ready_rd_ff, ready_rd_in, ready_wr_ff, ready_wr_in;
   logic [8:0]    ready_cnt_ff, ready_cnt_in;
   logic [5:0]    wc_ff, wc_in;
   logic [7:0]    init_ff, init_in;
   rsp_type       rsp_ff, rsp_in;
   logic          strobe_ff, strobe_in;

   logic          info_we, dep_we, free_we, ready_we;
   logic [7:0]    info_waddr, free_waddr, free_wdata, ready_waddr, ready_wdata;
   logic [11:0]   dep_waddr;
   slot_info_type info_wdata, cur;
   logic [$bits(slot_info_type)-1:0] info_rdata;
   handle_type    dep_wdata, dep_h;
   logic [31:0]   dep_rdata;
   logic [7:0]    free_rdata, ready_rdata;
   logic [8:0]    space;
   logic [5:0]    n_cur;
   logic          ok_s, last;
   logic [MAX_DEPENDENTS-1:0] match;

   tds_ram #(.WIDTH($bits(slot_info_type)), .DEPTH(SLOT_COUNT)) u_info (
      .clock(clock), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
      .raddr(t_ff), .rdata(info_rdata)
   );

   tds_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT * MAX_DEPENDENTS)) u_dep (
      .clock(clock), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
      .raddr({cmd_ff.task_slot, idx_ff[DEP_W-1:0]}), .rdata(dep_rdata)
   );

   tds_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT)) u_free (
      .clock(clock), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
      .raddr(free_rd_ff), .rdata(free_rdata)
   );

   tds_ram #(.WIDTH(8), .DEPTH(READY_DEPTH)) u_ready (
      .clock(clock), .we(ready_we), .waddr(ready_waddr), .wdata(ready_wdata),
      .raddr(ready_rd_ff), .rdata(ready_rdata)
   );

   assign cur   = slot_info_type'(info_rdata);
   assign dep_h = handle_type'(dep_rdata);
   assign ok_s  = cur.epoch == cmd_ff.task_epoch;
   assign n_cur = entries_for(cur, wc_ff);
   assign space = 9'(READY_DEPTH) - ready_cnt_ff;
   assign last  = (idx_ff + 5'd1) == cnt_ff;

   always_comb begin
      for (int j = 0; j < MAX_DEPENDENTS; j++) begin
         match[j] = (DEP_W'(j) < idx_ff[DEP_W-1:0]) && (hbuf_ff[j] == dep_h);
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cmd_in       = cmd_ff;
      t_in         = t_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      need_in      = need_ff;
      h_in         = h_ff;
      hbuf_in      = hbuf_ff;
      info_s_in    = info_s_ff;
      push_left_in = push_left_ff;
      push_slot_in = push_slot_ff;
      free_rd_in   = free_rd_ff;
      free_wr_in   = free_wr_ff;
      free_cnt_in  = free_cnt_ff;
      ready_rd_in  = ready_rd_ff;
      ready_wr_in  = ready_wr_ff;
      ready_cnt_in = ready_cnt_ff;
      wc_in        = csr_valid ? csr_data : wc_ff;
      init_in      = init_ff;
      rsp_in       = '0;
      strobe_in    = 1'b0;
      pop          = 1'b0;
      info_we      = 1'b0;
      info_waddr   = cmd_ff.task_slot;
      info_wdata   = cur;
      dep_we       = 1'b0;
      dep_waddr    = {cmd_ff.task_slot, info_s_ff.dep_cnt[DEP_W-1:0]};
      dep_wdata    = '{epoch: cmd_ff.other_epoch, slot: cmd_ff.other_slot};
      free_we      = 1'b0;
      free_waddr   = free_wr_ff;
      free_wdata   = cmd_ff.task_slot;
      ready_we     = 1'b0;
      ready_waddr  = ready_wr_ff;
      ready_wdata  = push_slot_ff;

      unique case (state_ff)
         S_INIT: begin
            info_we    = 1'b1;
            info_waddr = init_ff;
            info_wdata = '0;
            free_we    = 1'b1;
            free_waddr = init_ff;
            free_wdata = init_ff;
            init_in    = init_ff + 8'd1;
            if (init_ff == 8'(SLOT_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               cmd_in   = head_item;
               t_in     = head_item.task_slot;
               ret_in   = S_EXEC;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = ret_ff;
         end
         S_EXEC: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            unique case (cmd_ff.command)
               CMD_ALLOC: begin
                  if (free_cnt_ff == 9'd0) begin
                     rsp_in.status = ST_NO_FREE;
                  end else begin
                     strobe_in   = 1'b0;
                     t_in        = free_rdata;
                     free_rd_in  = free_rd_ff + 8'd1;
                     free_cnt_in = free_cnt_ff - 9'd1;
                     ret_in      = S_ALLOC_WR;
                     state_in    = S_WAIT;
                  end
               end
               CMD_SCALAR, CMD_INDEXED: begin
                  if (!ok_s) begin
                     rsp_in.status = ST_STALE;
                  end else begin
                     info_we         = 1'b1;
                     info_wdata.kind = cmd_ff.command[1:0];
                     if (cmd_ff.command == CMD_INDEXED) begin
                        info_wdata.limit = cmd_ff.work_limit;
                     end
                  end
               end
               CMD_ADD_DEP: begin
                  if (ok_s) begin
                     strobe_in = 1'b0;
                     info_s_in = cur;
                     t_in      = cmd_ff.other_slot;
                     ret_in    = S_ADD2;
                     state_in  = S_WAIT;
                  end
               end
               CMD_SUBMIT: begin
                  if (!ok_s || cur.deps == 9'd0) begin
                     rsp_in.status = ST_STALE;
                  end else if (cur.deps == 9'd1 && {3'd0, n_cur} > space) begin
                     rsp_in.status = ST_READY_FULL;
                  end else begin
                     info_we         = 1'b1;
                     info_wdata.deps = cur.deps - 9'd1;
                     if (cur.deps == 9'd1) begin
                        info_wdata.workers = n_cur;
                        push_left_in       = n_cur;
                        push_slot_in       = cmd_ff.task_slot;
                        ret_in             = S_IDLE;
                        state_in           = S_PUSH;
                     end
                  end
               end
               CMD_TAKE: begin
                  if (ready_cnt_ff == 9'd0) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     strobe_in    = 1'b0;
                     t_in         = ready_rdata;
                     ready_rd_in  = ready_rd_ff + 8'd1;
                     ready_cnt_in = ready_cnt_ff - 9'd1;
                     ret_in       = S_TAKE2;
                     state_in     = S_WAIT;
                  end
               end
               CMD_DONE: begin
                  if (!ok_s || cur.workers == 6'd0) begin
                     rsp_in.status = ST_STALE;
                  end else if (cur.workers > 6'd1) begin
                     info_we            = 1'b1;
                     info_wdata.workers = cur.workers - 6'd1;
                  end else begin
                     strobe_in = 1'b0;
                     info_s_in = cur;
                     cnt_in    = (cur.dep_cnt > 5'(MAX_DEPENDENTS)) ?
                                 5'(MAX_DEPENDENTS) : cur.dep_cnt;
                     idx_in    = 5'd0;
                     need_in   = 10'd0;
                     state_in  = (cur.dep_cnt == 5'd0) ? S_P1_END : S_P1_RDH;
                  end
               end
               CMD_QUERY: begin
                  rsp_in.finished = ~ok_s;
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
         end
         S_ALLOC_WR: begin
            info_we         = 1'b1;
            info_waddr      = t_ff;
            info_wdata      = '0;
            info_wdata.epoch = cur.epoch;
            info_wdata.deps = 9'd1;
            strobe_in       = 1'b1;
            rsp_in.out_slot = t_ff;
            rsp_in.out_epoch = cur.epoch;
            state_in        = S_IDLE;
         end
         S_ADD2: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            if (cur.epoch != cmd_ff.other_epoch) begin
               rsp_in.status = ST_STALE;
            end else if (info_s_ff.dep_cnt >= 5'(MAX_DEPENDENTS) ||
                         cur.deps >= 9'(DEPS_MAX)) begin
               rsp_in.status = ST_DEPS_FULL;
            end else begin
               dep_we             = 1'b1;
               info_we            = 1'b1;
               info_wdata         = info_s_ff;
               info_wdata.dep_cnt = info_s_ff.dep_cnt + 5'd1;
               if (cmd_ff.other_slot == cmd_ff.task_slot) begin
                  info_wdata.deps = info_s_ff.deps + 9'd1;
               end else begin
                  strobe_in = 1'b0;
                  info_s_in = cur;
                  state_in  = S_ADD3;
               end
            end
         end
         S_ADD3: begin
            info_we         = 1'b1;
            info_waddr      = cmd_ff.other_slot;
            info_wdata      = info_s_ff;
            info_wdata.deps = info_s_ff.deps + 9'd1;
            strobe_in       = 1'b1;
            state_in        = S_IDLE;
         end
         S_TAKE2: begin
            strobe_in        = 1'b1;
            rsp_in.out_slot  = t_ff;
            rsp_in.out_epoch = cur.epoch;
            rsp_in.out_kind  = cur.kind;
            state_in         = S_IDLE;
         end
         S_P1_RDH: begin
            state_in = S_P1_GOTH;
         end
         S_P1_GOTH: begin
            hbuf_in[idx_ff[DEP_W-1:0]] = dep_h;
            h_in     = dep_h;
            k_in     = 5'($countones(match));
            t_in     = dep_h.slot;
            ret_in   = S_P1_EVAL;
            state_in = S_WAIT;
         end
         S_P1_EVAL: begin
            if (cur.epoch == h_ff.epoch && cur.deps == ({4'd0, k_ff} + 9'd1)) begin
               need_in = need_ff + {4'd0, n_cur};
            end
            idx_in   = idx_ff + 5'd1;
            state_in = last ? S_P1_END : S_P1_RDH;
         end
         S_P1_END: begin
            if (need_ff > {1'b0, space}) begin
               strobe_in     = 1'b1;
               rsp_in.status = ST_READY_FULL;
               state_in      = S_IDLE;
            end else begin
               info_we            = 1'b1;
               info_wdata         = info_s_ff;
               info_wdata.workers = 6'd0;
               idx_in             = 5'd0;
               state_in           = (cnt_ff == 5'd0) ? S_FIN : S_P2_START;
            end
         end
         S_P2_START: begin
            h_in     = hbuf_ff[idx_ff[DEP_W-1:0]];
            t_in     = hbuf_ff[idx_ff[DEP_W-1:0]].slot;
            ret_in   = S_P2_EVAL;
            state_in = S_WAIT;
         end
         S_P2_EVAL: begin
            idx_in   = idx_ff + 5'd1;
            state_in = last ? S_FIN : S_P2_START;
            if (cur.epoch == h_ff.epoch && cur.deps != 9'd0) begin
               info_we         = 1'b1;
               info_waddr      = t_ff;
               info_wdata.deps = cur.deps - 9'd1;
               if (cur.deps == 9'd1) begin
                  info_wdata.workers = n_cur;
                  push_left_in       = n_cur;
                  push_slot_in       = t_ff;
                  ret_in             = last ? S_FIN : S_P2_START;
                  state_in           = S_PUSH;
               end
            end
         end
         S_FIN: begin
            t_in     = cmd_ff.task_slot;
            ret_in   = S_FIN2;
            state_in = S_WAIT;
         end
         S_FIN2: begin
            info_we          = 1'b1;
            info_wdata.epoch = cur.epoch + 1'b1;
            if (free_cnt_ff < 9'(SLOT_COUNT)) begin
               free_we     = 1'b1;
               free_wr_in  = free_wr_ff + 8'd1;
               free_cnt_in = free_cnt_ff + 9'd1;
            end
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         S_PUSH: begin
            ready_we     = 1'b1;
            ready_wr_in  = ready_wr_ff + 8'd1;
            ready_cnt_in = ready_cnt_ff + 9'd1;
            push_left_in = push_left_ff - 6'd1;
            if (push_left_ff == 6'd1) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      t_ff         <= t_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
      need_ff      <= need_in;
      h_ff         <= h_in;
      hbuf_ff      <= hbuf_in;
      info_s_ff    <= info_s_in;
      push_left_ff <= push_left_in;
      push_slot_ff <= push_slot_in;
      rsp_ff       <= rsp_in;
      ret_ff       <= ret_in;
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= 8'd0;
         free_rd_ff   <= 8'd0;
         free_wr_ff   <= 8'(SLOT_COUNT - 1);
         free_cnt_ff  <= 9'(SLOT_COUNT - 1);
         ready_rd_ff  <= 8'd0;
         ready_wr_ff  <= 8'd0;
         ready_cnt_ff <= 9'd0;
         wc_ff        <= 6'd1;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         free_rd_ff   <= free_rd_in;
         free_wr_ff   <= free_wr_in;
         free_cnt_ff  <= free_cnt_in;
         ready_rd_ff  <= ready_rd_in;
         ready_wr_ff  <= ready_wr_in;
         ready_cnt_ff <= ready_cnt_in;
         wc_ff        <= wc_in;
         strobe_ff    <= strobe_in;
      end
   end

   assign init_busy  = state_ff == S_INIT;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
